### hw/rtl/bra_pkg.sv
// Shared constants for the bitmap run allocator: field widths, command codes
// and the defaults for the top-level parameters.
// Depends on nothing; used by bitmap_run_allocator.
`timescale 1ns / 1ps

package bra_pkg;

  // Default geometry of the occupancy bitmap
  localparam int CAPACITY_DEF  = 1024;
  localparam int ROW_WIDTH_DEF = 64;

  // Field widths on the streams and the configuration port
  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;
  localparam int CFG_W = 11;

  // Bit positions are at most start + length, which stays below 4096
  localparam int POS_W = 12;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

endpackage

### hw/rtl/bra_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/bitmap_run_allocator.sv
// Top level of the bitmap run allocator: occupancy bitmap in a row memory,
// a row sequencer and the shared per-row search and mask unit.
// Depends on bra_pkg and bra_ram.
`timescale 1ns / 1ps

// Usage
// The input stream carries one command per beat: in_tuser holds the command
// (find, set, clear) and in_tdata the start index and the run length. Every
// beat yields exactly one result beat: out_tuser[0] is the found flag and
// out_tdata the start of the located run (zero unless a run was found).
// The bitmap is kept as rows of ROW_WIDTH bits in a memory and is walked one
// row per cycle through the single row search/mask unit, starting at row 0.
// A find stops at the first row holding a fitting run; set and clear stop at
// the row holding the end of the range. Each row is read through the
// registered memory port and then searched or masked; trivial commands
// offer their result in the cycle after acceptance. One command is in work at
// a time and in_tready is low until its result beat has been taken.
// After reset the memory is cleared one row per cycle, all ROW_COUNT rows
// (16 rows at the default geometry), with in_tready low. cfg_wr_en writes the
// number of bits in use at any time; it must only change while idle.
// While the receiver holds out_tready low the result beat simply waits.

module bitmap_run_allocator #(
  parameter int CAPACITY  = bra_pkg::CAPACITY_DEF,
  parameter int ROW_WIDTH = bra_pkg::ROW_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [23:0]              in_tdata,    // start_index[9:0], run_length[20:10], zero pad
  input  logic [bra_pkg::CMD_W-1:0] in_tuser,   // command[1:0]

  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,   // run_start[9:0], zero pad
  output logic                     out_tuser,   // found[0]

  input  logic                     cfg_wr_en,
  input  logic [bra_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int POS_W     = bra_pkg::POS_W;
  localparam int IDX_W     = bra_pkg::IDX_W;
  localparam int LEN_W     = bra_pkg::LEN_W;
  localparam int CFG_W     = bra_pkg::CFG_W;
  localparam int ROW_COUNT = (CAPACITY + ROW_WIDTH - 1) / ROW_WIDTH;
  localparam int AW        = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int BW        = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam int LW        = $clog2(ROW_WIDTH + 1);
  localparam int CFG_MAX   = (1 << CFG_W) - 1;
  localparam int CAP_CLIP  = (CAPACITY > CFG_MAX) ? CFG_MAX : CAPACITY;

  localparam logic [POS_W-1:0] RW_P   = POS_W'(ROW_WIDTH);
  localparam logic [POS_W-1:0] CAP_P  = POS_W'(CAP_CLIP);
  localparam logic [AW-1:0]    LAST_R = AW'(ROW_COUNT - 1);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [bra_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [POS_W-1:0]          lo_r, lo_nxt;
  logic [POS_W-1:0]          limit_r, limit_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic [AW-1:0]             rd_row_r, rd_row_nxt;
  logic [POS_W-1:0]          rd_base_r, rd_base_nxt;
  logic                      pend_r, pend_nxt;
  logic [AW-1:0]             pr_row_r, pr_row_nxt;
  logic [POS_W-1:0]          pr_base_r, pr_base_nxt;
  logic [POS_W-1:0]          carry_r, carry_nxt;
  logic                      found_r, found_nxt;
  logic [IDX_W-1:0]          start_r, start_nxt;
  logic [CFG_W-1:0]          biu_r;

  logic                      in_fire;
  logic [bra_pkg::CMD_W-1:0] in_cmd;
  logic [IDX_W-1:0]          in_first;
  logic [LEN_W-1:0]          in_len;
  logic [POS_W-1:0]          size;
  logic [POS_W-1:0]          req_end;
  logic [POS_W-1:0]          req_hi;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ROW_WIDTH-1:0]      ram_wdata;
  logic                      ram_re;
  logic [ROW_WIDTH-1:0]      ram_rdata;

  logic [LW-1:0]             lu [ROW_WIDTH];
  logic [POS_W-1:0]          run_b [ROW_WIDTH];
  logic [ROW_WIDTH-1:0]      hit;
  logic                      hit_any;
  logic [BW-1:0]             hb;
  logic                      row_last;
  logic [POS_W-1:0]          sb;
  logic [POS_W-1:0]          eb;
  logic [ROW_WIDTH-1:0]      mask;
  logic [ROW_WIDTH-1:0]      new_row;
  logic [POS_W-1:0]          hit_start;

  bra_ram #(
    .WIDTH (ROW_WIDTH),
    .DEPTH (ROW_COUNT),
    .AW    (AW)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_row_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_cmd     = in_tuser;
  assign in_first   = in_tdata[IDX_W-1:0];
  assign in_len     = in_tdata[IDX_W+LEN_W-1:IDX_W];

  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = found_r;
  assign out_tdata  = {{(16-IDX_W){1'b0}}, start_r};

  assign size    = ({1'b0, biu_r} > CAP_P) ? CAP_P : {1'b0, biu_r};
  assign req_end = POS_W'(in_first) + POS_W'(in_len);
  assign req_hi  = (req_end > size) ? size : req_end;

  // Row search: lu[b] is one above the highest used bit at or below b, or
  // zero if the row is free up to b. A doubling prefix builds it in log steps.
  always_comb begin
    for (int b = 0; b < ROW_WIDTH; b++) begin
      lu[b] = ram_rdata[b] ? LW'(b + 1) : '0;
    end
    for (int k = 1; k < ROW_WIDTH; k = k * 2) begin
      for (int b = ROW_WIDTH - 1; b >= k; b--) begin
        if (lu[b] == '0) begin
          lu[b] = lu[b-k];
        end
      end
    end
    for (int b = 0; b < ROW_WIDTH; b++) begin
      if (lu[b] != '0) begin
        run_b[b] = POS_W'(b + 1) - POS_W'(lu[b]);
      end else begin
        run_b[b] = carry_r + POS_W'(b + 1);
      end
      hit[b] = (pr_base_r + POS_W'(b) < limit_r) && (run_b[b] >= POS_W'(len_r));
    end
    hb = '0;
    for (int b = ROW_WIDTH - 1; b >= 0; b--) begin
      if (hit[b]) begin
        hb = BW'(b);
      end
    end
  end

  assign hit_any   = |hit;
  assign hit_start = pr_base_r + POS_W'(hb) + POS_W'(1) - POS_W'(len_r);
  assign row_last  = (pr_base_r + RW_P >= limit_r);

  // Range mask within the row being processed; limit_r is above pr_base_r.
  assign sb = (lo_r > pr_base_r) ? (lo_r - pr_base_r) : '0;
  assign eb = limit_r - pr_base_r;

  always_comb begin
    for (int b = 0; b < ROW_WIDTH; b++) begin
      mask[b] = (POS_W'(b) >= sb) && (POS_W'(b) < eb);
    end
  end

  assign new_row = (cmd_r == bra_pkg::CMD_SET) ? (ram_rdata | mask) : (ram_rdata & ~mask);

  assign ram_re    = (state_r == S_SCAN) && (rd_base_r < limit_r);
  assign ram_we    = (state_r == S_CLR)
                  || ((state_r == S_SCAN) && pend_r && (cmd_r != bra_pkg::CMD_FIND));
  assign ram_waddr = (state_r == S_CLR) ? rd_row_r : pr_row_r;
  assign ram_wdata = (state_r == S_CLR) ? '0 : new_row;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    lo_nxt      = lo_r;
    limit_nxt   = limit_r;
    len_nxt     = len_r;
    rd_row_nxt  = rd_row_r;
    rd_base_nxt = rd_base_r;
    pend_nxt    = pend_r;
    pr_row_nxt  = pr_row_r;
    pr_base_nxt = pr_base_r;
    carry_nxt   = carry_r;
    found_nxt   = found_r;
    start_nxt   = start_r;

    case (state_r)
      S_CLR: begin
        rd_row_nxt = rd_row_r + AW'(1);
        if (rd_row_r == LAST_R) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt     = in_cmd;
          len_nxt     = in_len;
          lo_nxt      = POS_W'(in_first);
          rd_row_nxt  = '0;
          rd_base_nxt = '0;
          pend_nxt    = 1'b0;
          carry_nxt   = '0;
          found_nxt   = 1'b0;
          start_nxt   = '0;
          state_nxt   = S_OUT;
          case (in_cmd)
            bra_pkg::CMD_FIND: begin
              if (in_len == '0) begin
                found_nxt = 1'b1;
              end else if (POS_W'(in_len) <= size) begin
                limit_nxt = size;
                state_nxt = S_SCAN;
              end
            end
            bra_pkg::CMD_SET, bra_pkg::CMD_CLEAR: begin
              if (POS_W'(in_first) < req_hi) begin
                limit_nxt = req_hi;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        pend_nxt    = ram_re;
        pr_row_nxt  = rd_row_r;
        pr_base_nxt = rd_base_r;
        if (ram_re) begin
          rd_row_nxt  = rd_row_r + AW'(1);
          rd_base_nxt = rd_base_r + RW_P;
        end
        if (pend_r) begin
          carry_nxt = run_b[ROW_WIDTH-1];
          if ((cmd_r == bra_pkg::CMD_FIND) && hit_any) begin
            found_nxt = 1'b1;
            start_nxt = hit_start[IDX_W-1:0];
            state_nxt = S_OUT;
          end else if (row_last) begin
            state_nxt = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      rd_row_r <= '0;
      pend_r   <= 1'b0;
      biu_r    <= bra_pkg::CFG_RESET;
    end else begin
      state_r  <= state_nxt;
      rd_row_r <= rd_row_nxt;
      pend_r   <= pend_nxt;
      if (cfg_wr_en) begin
        biu_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    lo_r      <= lo_nxt;
    limit_r   <= limit_nxt;
    len_r     <= len_nxt;
    rd_base_r <= rd_base_nxt;
    pr_row_r  <= pr_row_nxt;
    pr_base_r <= pr_base_nxt;
    carry_r   <= carry_nxt;
    found_r   <= found_nxt;
    start_r   <= start_nxt;
  end

  // The block never takes a new command while a result beat is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // A find of zero length answers found at start zero on the next cycle.
  a_zero_find: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser == bra_pkg::CMD_FIND) && (in_tdata[IDX_W+LEN_W-1:IDX_W] == '0))
    |=> (out_tvalid && out_tuser && (out_tdata == '0)))
    else $error("zero-length find did not answer at once");

  // Results without a found run always carry a zero start.
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("non-zero start on a result without a run");

  // Rows written by set or clear always lie below the clipped range end.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && pend_r && (cmd_r != bra_pkg::CMD_FIND))
    |-> (pr_base_r < limit_r))
    else $error("row written beyond the range end");

endmodule

### sim/testbench.sv
// Self-checking testbench for bitmap_run_allocator: a local bitmap predictor
// is checked against every result beat, under random stalls on both streams.
// Depends on bra_pkg and the bitmap_run_allocator RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int CMD_W = bra_pkg::CMD_W;
  localparam int IDX_W = bra_pkg::IDX_W;
  localparam int LEN_W = bra_pkg::LEN_W;
  localparam int CFG_W = bra_pkg::CFG_W;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_OFF     = 300;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] run_start;
  } alloc_result_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata    = '0;
  logic [CMD_W-1:0]  in_tuser    = bra_pkg::CMD_FIND;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [15:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = bra_pkg::CFG_RESET;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  bitmap_run_allocator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted state of the block
  logic [bra_pkg::CAPACITY_DEF-1:0] occ_map  = '0;
  logic [CFG_W-1:0]                 size_reg = bra_pkg::CFG_RESET;
  alloc_result_t                    pending_results[$];
  int                               mismatches = 0;

  // Sender and receiver pacing
  int burst_left      = 0;
  bit steady_sender   = 1'b0;
  int hold_req        = 0;
  int hold_cycles_req = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int rx_cycle        = 0;
  int quiet_cycles    = 0;
  alloc_result_t got_result;
  alloc_result_t want_result;

  function automatic int live_size();
    return (int'(size_reg) > bra_pkg::CAPACITY_DEF) ? bra_pkg::CAPACITY_DEF
                                                    : int'(size_reg);
  endfunction

  // Applies one command to the local bitmap and returns the result beat it gives.
  function automatic alloc_result_t predict_alloc(input logic [CMD_W-1:0] cmd,
                                                  input logic [IDX_W-1:0] first_idx,
                                                  input logic [LEN_W-1:0] len);
    alloc_result_t res;
    int sz;
    int run;
    int stop_pos;
    bit searching;
    res = '0;
    sz = live_size();
    case (cmd)
      bra_pkg::CMD_FIND: begin
        if (len == '0) begin
          res.found = 1'b1;
        end else if (int'(len) <= sz) begin
          run = 0;
          searching = 1'b1;
          for (int i = 0; i < sz && searching; i++) begin
            if (occ_map[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == int'(len)) begin
                res.found = 1'b1;
                res.run_start = IDX_W'(i + 1 - int'(len));
                searching = 1'b0;
              end
            end
          end
        end
      end
      bra_pkg::CMD_SET, bra_pkg::CMD_CLEAR: begin
        stop_pos = int'(first_idx) + int'(len);
        if (stop_pos > sz) stop_pos = sz;
        for (int i = int'(first_idx); i < stop_pos; i++)
          occ_map[i] = (cmd == bra_pkg::CMD_SET);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offers one command beat, with burst gaps, and records its expected result.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] first_idx,
                          input logic [LEN_W-1:0] len);
    int gap;
    if (!steady_sender && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, len, first_idx};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_alloc(cmd, first_idx, len));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input int value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_reg = CFG_W'(value);
  endtask

  // Mostly well-formed traffic sized to the live bitmap, with some wild fields.
  task automatic random_cmd();
    int sz;
    int hi;
    int pick;
    int flavour;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len;
    sz = live_size();
    hi = (sz == 0) ? 0 : sz - 1;
    idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 1023))
                                      : IDX_W'($urandom_range(0, hi));
    pick = $urandom_range(0, 99);
    flavour = $urandom_range(0, 9);
    if (pick < 3) begin
      cmd = CMD_UNUSED;
      len = LEN_W'($urandom_range(0, 2047));
    end else if (pick < 43) begin
      cmd = bra_pkg::CMD_FIND;
      if (flavour < 7) len = LEN_W'($urandom_range(1, 32));
      else if (flavour < 9) len = LEN_W'($urandom_range(0, sz));
      else len = LEN_W'($urandom_range(0, 2047));
    end else if (pick < 73) begin
      cmd = bra_pkg::CMD_SET;
      len = (flavour < 8) ? LEN_W'($urandom_range(1, 24)) : LEN_W'($urandom_range(0, 2047));
    end else begin
      cmd = bra_pkg::CMD_CLEAR;
      len = (flavour < 8) ? LEN_W'($urandom_range(1, 40)) : LEN_W'($urandom_range(0, 2047));
    end
    send_cmd(cmd, idx, len);
  endtask

  task automatic test_find_extremes();
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd0);
    send_cmd(bra_pkg::CMD_FIND, 10'd1023, 11'd1024);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd1025);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd2047);
    send_cmd(bra_pkg::CMD_SET, 10'd1023, 11'd2047);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd1024);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd1023);
    send_cmd(CMD_UNUSED, 10'd1023, 11'd2047);
    send_cmd(bra_pkg::CMD_SET, 10'd0, 11'd0);
  endtask

  task automatic test_range_clipping();
    send_cmd(bra_pkg::CMD_SET, 10'd0, 11'd1024);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd1);
    send_cmd(bra_pkg::CMD_CLEAR, 10'd1000, 11'd5);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd5);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd6);
    send_cmd(bra_pkg::CMD_CLEAR, 10'd0, 11'd0);
    send_cmd(bra_pkg::CMD_CLEAR, 10'd0, 11'd2047);
    send_cmd(bra_pkg::CMD_SET, 10'd64, 11'd64);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd65);
  endtask

  task automatic test_size_register();
    write_size(0);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd0);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd1);
    send_cmd(bra_pkg::CMD_SET, 10'd0, 11'd10);
    write_size(2047);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd896);
    // Shrinking the size must leave the bits above it untouched.
    write_size(64);
    send_cmd(bra_pkg::CMD_SET, 10'd0, 11'd2047);
    write_size(1);
    send_cmd(bra_pkg::CMD_CLEAR, 10'd0, 11'd1);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd1);
    write_size(1024);
    send_cmd(bra_pkg::CMD_FIND, 10'd0, 11'd64);
  endtask

  task automatic test_random_mix();
    int sizes[10];
    int counts[10];
    sizes  = '{1024, 2047, 64, 1, 0, 777, 128, 1000, 511, 1024};
    counts = '{250, 100, 150, 40, 25, 200, 150, 150, 120, 100};
    for (int p = 0; p < 10; p++) begin
      write_size(sizes[p]);
      for (int n = 0; n < counts[p]; n++) random_cmd();
    end
    write_size($urandom_range(2, 1023));
    for (int n = 0; n < 60; n++) random_cmd();
  endtask

  // The receiver holds off while the sender keeps offering back to back.
  task automatic test_backpressure();
    write_size(1024);
    hold_cycles_req <= HOLD_OFF;
    hold_req        <= hold_req + 1;
    steady_sender = 1'b1;
    for (int n = 0; n < 12; n++) random_cmd();
    steady_sender = 1'b0;
  endtask

  // Result checker and receiver pacing.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_result = '{found: out_tuser, run_start: out_tdata[IDX_W-1:0]};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: found=%0b run_start=%0d",
                     got_result.found, got_result.run_start);
        end else begin
          want_result = pending_results.pop_front();
          if (got_result !== want_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected found=%0b run_start=%0d,",
                        " got found=%0b run_start=%0d"},
                       want_result.found, want_result.run_start,
                       got_result.found, got_result.run_start);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_cycles_req;
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 150) % 4)
          0: out_tready <= 1'b1;
          1: out_tready <= (rx_cycle % 5) != 0;
          2: out_tready <= ($urandom_range(0, 9) < 6);
          default: out_tready <= ((rx_cycle / 7) % 2) == 0;
        endcase
      end
    end
  end

  // Ends the run if neither stream moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bitmap_run_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_find_extremes();
    test_range_clipping();
    test_size_register();
    test_backpressure();
    test_random_mix();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("bitmap_run_allocator: match");
    end else begin
      $display("bitmap_run_allocator: mismatch");
    end
    $finish;
  end

endmodule
